// ===== rtl/core/camera_view_matrix_builder_assert.svh =====
// Assertion macros for the camera view matrix builder.
// No dependencies; included by the top level.
`ifndef CAMERA_VIEW_MATRIX_BUILDER_ASSERT_SVH
`define CAMERA_VIEW_MATRIX_BUILDER_ASSERT_SVH

// ante implies cons on the same edge
`define CVMB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cvmb implication check failed");

// expr never true out of reset
`define CVMB_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("cvmb never check failed");

`endif

// ===== rtl/core/cvmb_pkg.sv =====
// Shared constants and helpers for the camera view matrix builder.
// No dependencies.
package cvmb_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int WORD_BITS   = 32;
  localparam int TOP_BIT     = 29;                  // block shift target bit
  localparam int NV_W        = 50;                  // normalizer input width
  localparam int SM_W        = TOP_BIT + 1;         // shifted magnitude
  localparam int SQ_W        = 2 * SM_W + 2;        // sum of squares
  localparam int SQRT_STEPS  = SQ_W / 2;            // root bits
  localparam int RT_W        = SQRT_STEPS;
  localparam int QT_W        = FRAC_BITS + 1;       // quotient bits, max is one
  localparam int DV_W        = SM_W + FRAC_BITS + 2;
  localparam int TB_W        = 7;
  localparam int AX_W        = FRAC_BITS + 2;       // unit axis value width
  localparam int NR_W        = FRAC_BITS + 3;       // rebuilt right axis width
  localparam int NORM_LAT    = 7 + SQRT_STEPS + QT_W;

  localparam logic signed [WORD_BITS-1:0] UNIT_POS = WORD_BITS'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [WORD_BITS-1:0] UNIT_NEG = -UNIT_POS;

  // index of highest set bit, 0 for zero input
  function automatic logic [TB_W-1:0] top_bit(input logic [63:0] v);
    logic [TB_W-1:0] t;
    t = '0;
    for (int k = 0; k < 64; k++) begin
      if (v[k]) t = TB_W'(k);
    end
    return t;
  endfunction

  // move magnitude so that bit tb lands on TOP_BIT
  function automatic logic [SM_W-1:0] blk_shift(input logic [63:0] m,
                                                 input logic [TB_W-1:0] tb);
    logic [63:0] s;
    if (tb > TB_W'(TOP_BIT)) s = m >> (tb - TB_W'(TOP_BIT));
    else s = m << (TB_W'(TOP_BIT) - tb);
    return s[SM_W-1:0];
  endfunction

  // |x| rounded half up by FRAC_BITS, signed by neg, saturated to the word
  function automatic logic [WORD_BITS-1:0] rnd_sat(input logic signed [63:0] x,
                                                   input logic neg);
    logic [63:0] m;
    logic [63:0] r;
    logic [63:0] lim;
    m   = x[63] ? 64'(-x) : 64'(x);
    r   = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    lim = 64'd1 << (WORD_BITS - 1);
    if (neg) begin
      if (r > lim) r = lim;
      r = -r;
    end else begin
      if (r > lim - 64'd1) r = lim - 64'd1;
    end
    return r[WORD_BITS-1:0];
  endfunction

endpackage

// ===== rtl/core/cvmb_norm3.sv =====
// Pipelined 3-vector normalizer: block shift, square sum, bitwise root, divide.
// Depends on cvmb_pkg.
module cvmb_norm3
  import cvmb_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic signed [NV_W-1:0]      c_i [3],
  output logic                        valid_o,
  output logic signed [WORD_BITS-1:0] n_o [3]
);

  typedef struct packed {
    logic [2:0]           neg;
    logic                 zero;
    logic [2:0][SM_W-1:0] m;
  } side_t;

  logic [NORM_LAT-1:0] vld_q;

  logic [2:0][NV_W-1:0] mag_q, mag2_q;
  logic [2:0]           neg1_q, neg2_q;
  logic [TB_W-1:0]      tb_q;
  logic                 zero2_q;
  side_t                sd3_q, sd4_q;
  logic [2:0][2*SM_W-1:0] sq_q;

  logic [SQ_W-1:0] sv_q [SQRT_STEPS+1];
  logic [SQ_W-1:0] sv_d [SQRT_STEPS+1];
  logic [SQ_W-1:0] sr_q [SQRT_STEPS+1];
  logic [SQ_W-1:0] sr_d [SQRT_STEPS+1];
  side_t           ss_q [SQRT_STEPS+1];

  logic [2:0][DV_W-1:0] dr_q [QT_W+1];
  logic [2:0][DV_W-1:0] dr_d [QT_W+1];
  logic [2:0][QT_W-1:0] dq_q [QT_W+1];
  logic [2:0][QT_W-1:0] dq_d [QT_W+1];
  logic [RT_W-1:0]      dd_q [QT_W+1];
  logic [3:0]           dsd_q [QT_W+1];   // {zero, neg[2:0]}

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NORM_LAT-2:0], valid_i};
    end
  end
  assign valid_o = vld_q[NORM_LAT-1];

  // root: one result bit per stage
  always_comb begin
    logic [SQ_W-1:0] bit_v;
    logic [SQ_W-1:0] trial;
    sv_d[0] = SQ_W'(sq_q[0]) + SQ_W'(sq_q[1]) + SQ_W'(sq_q[2]);
    sr_d[0] = '0;
    for (int k = 1; k <= SQRT_STEPS; k++) begin
      bit_v = SQ_W'(1) << (2 * (SQRT_STEPS - k));
      trial = sr_q[k-1] + bit_v;
      if (sv_q[k-1] >= trial) begin
        sv_d[k] = sv_q[k-1] - trial;
        sr_d[k] = (sr_q[k-1] >> 1) + bit_v;
      end else begin
        sv_d[k] = sv_q[k-1];
        sr_d[k] = sr_q[k-1] >> 1;
      end
    end
  end

  // restoring divide, three lanes, one quotient bit per stage
  always_comb begin
    logic [DV_W-1:0] den;
    for (int i = 0; i < 3; i++) begin
      dr_d[0][i] = (DV_W'(ss_q[SQRT_STEPS].m[i]) << FRAC_BITS)
                 + DV_W'(sr_q[SQRT_STEPS][RT_W-1:1]);
      dq_d[0][i] = '0;
    end
    for (int j = 1; j <= QT_W; j++) begin
      den = DV_W'(dd_q[j-1]) << (QT_W - j);
      for (int i = 0; i < 3; i++) begin
        if (dr_q[j-1][i] >= den) begin
          dr_d[j][i] = dr_q[j-1][i] - den;
          dq_d[j][i] = dq_q[j-1][i] | (QT_W'(1) << (QT_W - j));
        end else begin
          dr_d[j][i] = dr_q[j-1][i];
          dq_d[j][i] = dq_q[j-1][i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      neg1_q[i] <= c_i[i][NV_W-1];
      mag_q[i]  <= c_i[i][NV_W-1] ? NV_W'(-c_i[i]) : NV_W'(c_i[i]);
    end
    mag2_q  <= mag_q;
    neg2_q  <= neg1_q;
    tb_q    <= top_bit(64'(mag_q[0] | mag_q[1] | mag_q[2]));
    zero2_q <= (mag_q[0] | mag_q[1] | mag_q[2]) == '0;

    sd3_q.neg  <= neg2_q;
    sd3_q.zero <= zero2_q;
    for (int i = 0; i < 3; i++) begin
      sd3_q.m[i] <= blk_shift(64'(mag2_q[i]), tb_q);
      sq_q[i]    <= sd3_q.m[i] * sd3_q.m[i];
    end
    sd4_q <= sd3_q;

    ss_q[0] <= sd4_q;
    for (int k = 0; k <= SQRT_STEPS; k++) begin
      sv_q[k] <= sv_d[k];
      sr_q[k] <= sr_d[k];
    end
    for (int k = 1; k <= SQRT_STEPS; k++) ss_q[k] <= ss_q[k-1];

    dd_q[0]  <= sr_q[SQRT_STEPS][RT_W-1:0];
    dsd_q[0] <= {ss_q[SQRT_STEPS].zero, ss_q[SQRT_STEPS].neg};
    for (int j = 0; j <= QT_W; j++) begin
      dr_q[j] <= dr_d[j];
      dq_q[j] <= dq_d[j];
    end
    for (int j = 1; j <= QT_W; j++) begin
      dd_q[j]  <= dd_q[j-1];
      dsd_q[j] <= dsd_q[j-1];
    end

    for (int i = 0; i < 3; i++) begin
      if (dsd_q[QT_W][3]) n_o[i] <= '0;
      else if (dsd_q[QT_W][i]) n_o[i] <= -WORD_BITS'(dq_q[QT_W][i]);
      else n_o[i] <= WORD_BITS'(dq_q[QT_W][i]);
    end
  end

endmodule

// ===== rtl/core/camera_view_matrix_builder.sv =====
// Camera view matrix builder: orthonormal left-handed basis and translation.
// Depends on cvmb_pkg, cvmb_norm3 and camera_view_matrix_builder_assert.svh.
//
// Usage: drive the right, look and position vectors (signed Q16.16) with
// start high; a transfer happens at any edge where start is high and busy is
// low. busy is always low: the datapath is a free-running pipeline and takes
// one item every cycle. Each item yields exactly one result, shown for one
// cycle with done_o high: right, up and look axes plus the three translation
// terms. Each normalizer holds 55 stages; the bulk of them are the 31
// bitwise square root steps and 17 divide steps. Results leave in input
// order. Reset clears only the valid bits; items in flight are dropped. The
// receiver cannot stall, so nothing is held back.
module camera_view_matrix_builder
  import cvmb_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [WORD_BITS-1:0] right_x_i,
  input  logic signed [WORD_BITS-1:0] right_y_i,
  input  logic signed [WORD_BITS-1:0] right_z_i,
  input  logic signed [WORD_BITS-1:0] look_x_i,
  input  logic signed [WORD_BITS-1:0] look_y_i,
  input  logic signed [WORD_BITS-1:0] look_z_i,
  input  logic signed [WORD_BITS-1:0] pos_x_i,
  input  logic signed [WORD_BITS-1:0] pos_y_i,
  input  logic signed [WORD_BITS-1:0] pos_z_i,
  output logic                        done_o,
  output logic signed [WORD_BITS-1:0] axis_right_x_o,
  output logic signed [WORD_BITS-1:0] axis_right_y_o,
  output logic signed [WORD_BITS-1:0] axis_right_z_o,
  output logic signed [WORD_BITS-1:0] axis_up_x_o,
  output logic signed [WORD_BITS-1:0] axis_up_y_o,
  output logic signed [WORD_BITS-1:0] axis_up_z_o,
  output logic signed [WORD_BITS-1:0] axis_look_x_o,
  output logic signed [WORD_BITS-1:0] axis_look_y_o,
  output logic signed [WORD_BITS-1:0] axis_look_z_o,
  output logic signed [WORD_BITS-1:0] trans_right_o,
  output logic signed [WORD_BITS-1:0] trans_up_o,
  output logic signed [WORD_BITS-1:0] trans_look_o
);

`include "camera_view_matrix_builder_assert.svh"

  localparam int RS_W   = SM_W + 1;
  localparam int RS_DLY = NORM_LAT - 3;
  localparam int P_DLY  = 2 * NORM_LAT + 4;
  localparam int NL_DLY = NORM_LAT + 6;
  localparam int U_DLY  = 4;
  localparam int NR_DLY = 2;
  localparam int XP_W   = AX_W + RS_W;
  localparam int UP_W   = 2 * AX_W;
  localparam int DP_W   = WORD_BITS + NR_W;

  // the pipeline never holds off the sender
  assign busy = 1'b0;

  // input stage
  logic                        v0_q;
  logic signed [WORD_BITS-1:0] rx_q [3];
  logic signed [WORD_BITS-1:0] lk_q [3];
  logic signed [WORD_BITS-1:0] ps_q [3];
  logic signed [NV_W-1:0]      lka   [3];

  // look normalizer (A) and up normalizer (B)
  logic                        na_vld, nb_vld;
  logic signed [WORD_BITS-1:0] nla [3];
  logic signed [WORD_BITS-1:0] nub [3];

  // right vector block shift, three stages, then delay to meet L
  logic [2:0][WORD_BITS-1:0] rmag_q, rmag2_q;
  logic [2:0]                rneg_q, rneg2_q;
  logic [TB_W-1:0]           rtb_q;
  logic [2:0][RS_W-1:0]      rs_q;
  logic [2:0][RS_W-1:0]      rsd_q [RS_DLY];

  // cross product L x R
  logic                        x1v_q, x2v_q;
  logic signed [XP_W-1:0]      pxa_q [3];
  logic signed [XP_W-1:0]      pxb_q [3];
  logic signed [NV_W-1:0]      c_q   [3];

  // delay lines for side data
  logic [2:0][WORD_BITS-1:0] pd_q  [P_DLY];
  logic [2:0][WORD_BITS-1:0] nld_q [NL_DLY];
  logic [2:0][WORD_BITS-1:0] ud_q  [U_DLY];
  logic [2:0][WORD_BITS-1:0] nrd_q [NR_DLY];

  // right axis rebuild U x L, dot products, output valid chain
  logic signed [UP_W-1:0]      ua_q  [3];
  logic signed [UP_W-1:0]      ub_q  [3];
  logic signed [WORD_BITS-1:0] nr_q  [3];
  logic signed [DP_W-1:0]      dp_q  [3][3];
  logic signed [DP_W+1:0]      ds_q  [3];
  logic [4:0]                  vt_q;

  logic signed [AX_W-1:0] lnl [3];
  logic signed [AX_W-1:0] lnu [3];
  logic signed [NR_W-1:0] ax  [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q  <= 1'b0;
      x1v_q <= 1'b0;
      x2v_q <= 1'b0;
      vt_q  <= '0;
    end else begin
      v0_q  <= start && !busy;
      x1v_q <= na_vld;
      x2v_q <= x1v_q;
      vt_q  <= {vt_q[3:0], nb_vld};
    end
  end
  assign done_o = vt_q[4];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lka[i] = NV_W'(lk_q[i]);
      lnl[i] = nla[i][AX_W-1:0];
      lnu[i] = nub[i][AX_W-1:0];
      // axes at the dot product stage: 0 right, 1 up, 2 look
      ax[0][i] = nr_q[i][NR_W-1:0];
      ax[1][i] = NR_W'($signed(ud_q[1][i][AX_W-1:0]));
      ax[2][i] = NR_W'($signed(nld_q[NORM_LAT+3][i][AX_W-1:0]));
    end
  end

  cvmb_norm3 u_norm_look (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .c_i     (lka),
    .valid_o (na_vld),
    .n_o     (nla)
  );

  cvmb_norm3 u_norm_up (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (x2v_q),
    .c_i     (c_q),
    .valid_o (nb_vld),
    .n_o     (nub)
  );

  always_ff @(posedge clk_i) begin
    rx_q <= '{right_x_i, right_y_i, right_z_i};
    lk_q <= '{look_x_i, look_y_i, look_z_i};
    ps_q <= '{pos_x_i, pos_y_i, pos_z_i};

    // R block shift; a zero R shifts to zero by itself
    for (int i = 0; i < 3; i++) begin
      rneg_q[i] <= rx_q[i][WORD_BITS-1];
      rmag_q[i] <= rx_q[i][WORD_BITS-1] ? WORD_BITS'(-rx_q[i]) : WORD_BITS'(rx_q[i]);
    end
    rmag2_q <= rmag_q;
    rneg2_q <= rneg_q;
    rtb_q   <= top_bit(64'(rmag_q[0] | rmag_q[1] | rmag_q[2]));
    for (int i = 0; i < 3; i++) begin
      if (rneg2_q[i]) rs_q[i] <= -RS_W'(blk_shift(64'(rmag2_q[i]), rtb_q));
      else rs_q[i] <= RS_W'(blk_shift(64'(rmag2_q[i]), rtb_q));
    end
    rsd_q[0] <= rs_q;
    for (int k = 1; k < RS_DLY; k++) rsd_q[k] <= rsd_q[k-1];

    pd_q[0] <= {ps_q[2], ps_q[1], ps_q[0]};
    for (int k = 1; k < P_DLY; k++) pd_q[k] <= pd_q[k-1];
    nld_q[0] <= {nla[2], nla[1], nla[0]};
    for (int k = 1; k < NL_DLY; k++) nld_q[k] <= nld_q[k-1];
    ud_q[0] <= {nub[2], nub[1], nub[0]};
    for (int k = 1; k < U_DLY; k++) ud_q[k] <= ud_q[k-1];
    nrd_q[0] <= {nr_q[2], nr_q[1], nr_q[0]};
    for (int k = 1; k < NR_DLY; k++) nrd_q[k] <= nrd_q[k-1];

    // L x R products, then differences
    pxa_q[0] <= lnl[1] * $signed(rsd_q[RS_DLY-1][2]);
    pxb_q[0] <= lnl[2] * $signed(rsd_q[RS_DLY-1][1]);
    pxa_q[1] <= lnl[2] * $signed(rsd_q[RS_DLY-1][0]);
    pxb_q[1] <= lnl[0] * $signed(rsd_q[RS_DLY-1][2]);
    pxa_q[2] <= lnl[0] * $signed(rsd_q[RS_DLY-1][1]);
    pxb_q[2] <= lnl[1] * $signed(rsd_q[RS_DLY-1][0]);
    for (int i = 0; i < 3; i++) c_q[i] <= NV_W'(pxa_q[i]) - NV_W'(pxb_q[i]);

    // U x L with the look axis delayed to meet U
    ua_q[0] <= lnu[1] * $signed(nld_q[NORM_LAT+1][2][AX_W-1:0]);
    ub_q[0] <= lnu[2] * $signed(nld_q[NORM_LAT+1][1][AX_W-1:0]);
    ua_q[1] <= lnu[2] * $signed(nld_q[NORM_LAT+1][0][AX_W-1:0]);
    ub_q[1] <= lnu[0] * $signed(nld_q[NORM_LAT+1][2][AX_W-1:0]);
    ua_q[2] <= lnu[0] * $signed(nld_q[NORM_LAT+1][1][AX_W-1:0]);
    ub_q[2] <= lnu[1] * $signed(nld_q[NORM_LAT+1][0][AX_W-1:0]);
    for (int i = 0; i < 3; i++) begin
      nr_q[i] <= rnd_sat(64'(ua_q[i]) - 64'(ub_q[i]),
                         ua_q[i] < ub_q[i]);
    end

    // P . axis: products, sum, then negate with rounding
    for (int a = 0; a < 3; a++) begin
      for (int i = 0; i < 3; i++) begin
        dp_q[a][i] <= $signed(pd_q[P_DLY-1][i]) * ax[a][i];
      end
      ds_q[a] <= (DP_W+2)'(dp_q[a][0]) + (DP_W+2)'(dp_q[a][1]) + (DP_W+2)'(dp_q[a][2]);
    end
    trans_right_o <= rnd_sat(64'(ds_q[0]), !ds_q[0][DP_W+1]);
    trans_up_o    <= rnd_sat(64'(ds_q[1]), !ds_q[1][DP_W+1]);
    trans_look_o  <= rnd_sat(64'(ds_q[2]), !ds_q[2][DP_W+1]);

    axis_right_x_o <= nrd_q[NR_DLY-1][0];
    axis_right_y_o <= nrd_q[NR_DLY-1][1];
    axis_right_z_o <= nrd_q[NR_DLY-1][2];
    axis_up_x_o    <= ud_q[U_DLY-1][0];
    axis_up_y_o    <= ud_q[U_DLY-1][1];
    axis_up_z_o    <= ud_q[U_DLY-1][2];
    axis_look_x_o  <= nld_q[NL_DLY-1][0];
    axis_look_y_o  <= nld_q[NL_DLY-1][1];
    axis_look_z_o  <= nld_q[NL_DLY-1][2];
  end

  // the sender is never held off
  `CVMB_ASSERT_NEVER(a_never_busy, clk_i, rst_ni, busy)

  // a degenerate up axis must give a zero right axis
  `CVMB_ASSERT_IMP(a_zero_up_zero_right, clk_i, rst_ni,
    done_o && axis_up_x_o == '0 && axis_up_y_o == '0 && axis_up_z_o == '0,
    axis_right_x_o == '0 && axis_right_y_o == '0 && axis_right_z_o == '0)

  // normalized look components never exceed one
  `CVMB_ASSERT_IMP(a_look_in_unit, clk_i, rst_ni, done_o,
    axis_look_x_o <= UNIT_POS && axis_look_x_o >= UNIT_NEG &&
    axis_look_y_o <= UNIT_POS && axis_look_y_o >= UNIT_NEG &&
    axis_look_z_o <= UNIT_POS && axis_look_z_o >= UNIT_NEG)

endmodule
